// File: rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int FIELD_BITS   = 32;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef struct packed {
        t_func                         func;
        logic signed [FIELD_BITS-1:0]  key;
        logic        [FIELD_BITS-1:0]  payload;
    } t_in_item;

    typedef struct packed {
        logic                          success;
        logic signed [FIELD_BITS-1:0]  out_key;
        logic        [FIELD_BITS-1:0]  out_payload;
    } t_out_item;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

// File: rtl/sorted_priority_queue_core.sv
// sorted priority queue top level: chain of entry cells plus count and result register
//
// Bounded max-priority queue kept sorted by descending key in a row of cells.
// An item is taken at a rising edge where i_start is high and o_busy is low;
// o_busy stays low, so one item can be issued every cycle.
// i_item.func selects enqueue or dequeue. Enqueue places the entry ahead of
// any stored entry with an equal key; dequeue removes the greatest key.
// Every item gives exactly one result on o_result, marked by o_valid for one
// cycle, in the cycle after the item was taken.
// All cells compare against the broadcast key in parallel and shift by one
// position in the same edge, so the insert depth does not change timing.
// Enqueue on a full queue fails (success 0) and echoes the item; dequeue on an
// empty queue fails and returns zero key and payload.
// Reset (synchronous, i_rst_n low) empties the queue; stored entries are not
// cleared. Results cannot be held off, so there is no output stall.
module sorted_priority_queue_core #(
    parameter int DEPTH        = spq_pkg::DEPTH,
    parameter int KEY_BITS     = spq_pkg::KEY_BITS,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  spq_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_valid,
    output spq_pkg::t_out_item o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FW    = spq_pkg::FIELD_BITS;

    logic               accept;
    logic               full, empty;
    spq_pkg::t_cell_ctl ctl;

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_valid;
    spq_pkg::t_out_item r_result, n_result;

    logic signed [KEY_BITS-1:0] new_key;
    logic [PAYLOAD_BITS-1:0]    new_pay;
    logic [63:0]                key_sext;
    logic [64:0]                head_key_ext;
    logic [64:0]                head_pay_ext;
    logic [64:0]                in_pay_ext;

    logic signed [KEY_BITS-1:0] cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0]    cell_pay [DEPTH];
    logic                       cell_gt  [DEPTH];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    assign ctl.enq = accept && (i_item.func == spq_pkg::FUNC_ENQ) && !full;
    assign ctl.deq = accept && (i_item.func == spq_pkg::FUNC_DEQ) && !empty;

    // input key sign-extended then cut to the stored key width
    assign key_sext   = {{32{i_item.key[FW-1]}}, i_item.key};
    assign new_key    = key_sext[KEY_BITS-1:0];
    assign in_pay_ext = {33'b0, i_item.payload};
    assign new_pay    = in_pay_ext[PAYLOAD_BITS-1:0];

    // stored fields are zero-extended or cut back to the port width
    assign head_key_ext = {{(65-KEY_BITS){1'b0}}, cell_key[0]};
    assign head_pay_ext = {{(65-PAYLOAD_BITS){1'b0}}, cell_pay[0]};

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                       occ;
        logic                       left_gt;
        logic signed [KEY_BITS-1:0] left_key, right_key;
        logic [PAYLOAD_BITS-1:0]    left_pay, right_pay;

        assign occ = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_head
            assign left_gt  = 1'b1;
            assign left_key = new_key;
            assign left_pay = new_pay;
        end else begin : g_body
            assign left_gt  = cell_gt[i-1];
            assign left_key = cell_key[i-1];
            assign left_pay = cell_pay[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_key = cell_key[i];
            assign right_pay = cell_pay[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
            assign right_pay = cell_pay[i+1];
        end

        spq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (occ),
            .i_new_key   (new_key),
            .i_new_pay   (new_pay),
            .i_left_gt   (left_gt),
            .i_left_key  (left_key),
            .i_left_pay  (left_pay),
            .i_right_key (right_key),
            .i_right_pay (right_pay),
            .o_gt        (cell_gt[i]),
            .o_key       (cell_key[i]),
            .o_pay       (cell_pay[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_result = r_result;
        if (accept) begin
            unique case (i_item.func)
                spq_pkg::FUNC_ENQ: begin
                    n_result.success     = !full;
                    n_result.out_key     = i_item.key;
                    n_result.out_payload = i_item.payload;
                end
                spq_pkg::FUNC_DEQ: begin
                    n_result.success     = !empty;
                    n_result.out_key     = empty ? '0 : head_key_ext[FW-1:0];
                    n_result.out_payload = empty ? '0 : head_pay_ext[FW-1:0];
                end
                default: begin
                    n_result = r_result;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result without an accepted item");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.enq |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not grow the queue");

    a_deq_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.func == spq_pkg::FUNC_DEQ && empty)
        |=> (o_valid && !o_result.success && o_result.out_key == '0
             && o_result.out_payload == '0))
        else $error("failed dequeue returned data");

endmodule

// File: rtl/spq_cell.sv
// one slot of the sorted chain: holds an entry, shifts toward tail or head
module spq_cell #(
    parameter int KEY_BITS     = spq_pkg::KEY_BITS,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
) (
    input  logic                       i_clk,
    input  spq_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_occ,
    input  logic signed [KEY_BITS-1:0] i_new_key,
    input  logic [PAYLOAD_BITS-1:0]    i_new_pay,
    input  logic                       i_left_gt,
    input  logic signed [KEY_BITS-1:0] i_left_key,
    input  logic [PAYLOAD_BITS-1:0]    i_left_pay,
    input  logic signed [KEY_BITS-1:0] i_right_key,
    input  logic [PAYLOAD_BITS-1:0]    i_right_pay,
    output logic                       o_gt,
    output logic signed [KEY_BITS-1:0] o_key,
    output logic [PAYLOAD_BITS-1:0]    o_pay
);

    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [PAYLOAD_BITS-1:0]    r_pay, n_pay;

    // entry stays ahead of the new key only when strictly greater
    assign o_gt = i_occ && (r_key > i_new_key);

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        if (i_ctl.enq) begin
            priority if (o_gt) begin
                n_key = r_key;
                n_pay = r_pay;
            end else if (i_left_gt) begin
                n_key = i_new_key;
                n_pay = i_new_pay;
            end else begin
                n_key = i_left_key;
                n_pay = i_left_pay;
            end
        end else if (i_ctl.deq) begin
            n_key = i_right_key;
            n_pay = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

    assign o_key = r_key;
    assign o_pay = r_pay;

endmodule

// File: tb/tb.sv
// testbench for sorted_priority_queue_core: queued-item driver, result monitor, sorted-list predictor
module tb;

    localparam int IDLE_LIMIT = 400;

    typedef struct {
        spq_pkg::t_in_item item;
        int unsigned       gap;
    } t_stim;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    spq_pkg::t_in_item  i_item;
    logic               o_busy;
    logic               o_valid;
    spq_pkg::t_out_item o_result;

    t_stim              stim_items[$];
    spq_pkg::t_out_item pending_results[$];
    t_stim              next_stim;
    logic               have_next;
    int unsigned        gap_left;
    int                 error_count;
    int                 idle_cycles;

    // predictor state: entries sorted by descending key, head at index 0
    logic signed [spq_pkg::FIELD_BITS-1:0] model_keys[spq_pkg::DEPTH];
    logic        [spq_pkg::FIELD_BITS-1:0] model_pays[spq_pkg::DEPTH];
    int                                    model_count;

    sorted_priority_queue_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // applies one item to the sorted list and returns the result it gives
    function automatic spq_pkg::t_out_item queue_op_result(input spq_pkg::t_in_item it);
        spq_pkg::t_out_item res;
        int                 pos;
        int                 i;
        res.success     = 1'b0;
        res.out_key     = it.key;
        res.out_payload = it.payload;
        if (it.func == spq_pkg::FUNC_ENQ) begin
            if (model_count < spq_pkg::DEPTH) begin
                pos = 0;
                // new entry goes ahead of equal keys
                while (pos < model_count && model_keys[pos] > $signed(it.key))
                    pos++;
                for (i = model_count; i > pos; i--) begin
                    model_keys[i] = model_keys[i-1];
                    model_pays[i] = model_pays[i-1];
                end
                model_keys[pos] = it.key;
                model_pays[pos] = it.payload;
                model_count++;
                res.success = 1'b1;
            end
        end else begin
            res = '0;
            if (model_count > 0) begin
                res.success     = 1'b1;
                res.out_key     = model_keys[0];
                res.out_payload = model_pays[0];
                for (i = 1; i < model_count; i++) begin
                    model_keys[i-1] = model_keys[i];
                    model_pays[i-1] = model_pays[i];
                end
                model_count--;
            end
        end
        return res;
    endfunction

    task automatic add_item(input spq_pkg::t_func f, input logic [31:0] k,
                            input logic [31:0] p, input int unsigned g);
        t_stim s;
        s.item.func    = f;
        s.item.key     = k;
        s.item.payload = p;
        s.gap          = g;
        stim_items.push_back(s);
    endtask

    // random key: four draws in ten from a narrow band and two from fixed extremes, so equal keys are common
    function automatic logic [31:0] draw_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 7) - 4;
            4, 5, 6, 7: return $urandom;
            8:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default:    return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
        endcase
    endfunction

    // driver: one nonblocking write of i_start per edge
    always @(posedge i_clk) begin
        logic drive_next;
        drive_next = i_start;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                pending_results.push_back(queue_op_result(i_item));
                drive_next = 1'b0;
            end
            if (!drive_next) begin
                if (!have_next && stim_items.size() > 0) begin
                    next_stim = stim_items.pop_front();
                    gap_left  = next_stim.gap;
                    have_next = 1'b1;
                end
                if (have_next) begin
                    if (gap_left == 0) begin
                        i_item     <= next_stim.item;
                        drive_next = 1'b1;
                        have_next  = 1'b0;
                    end else begin
                        gap_left--;
                    end
                end
            end
        end
        i_start <= drive_next;
    end

    // monitor: each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        spq_pkg::t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0b %h %h", $time,
                         o_result.success, o_result.out_key, o_result.out_payload);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.success !== want.success) begin
                    $display("%0t: success mismatch, expected %0b, got %0b", $time,
                             want.success, o_result.success);
                    error_count++;
                end
                if (o_result.out_key !== want.out_key) begin
                    $display("%0t: out_key mismatch, expected %h, got %h", $time,
                             want.out_key, o_result.out_key);
                    error_count++;
                end
                if (o_result.out_payload !== want.out_payload) begin
                    $display("%0t: out_payload mismatch, expected %h, got %h", $time,
                             want.out_payload, o_result.out_payload);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where neither an item nor a result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no progress for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          n;
        int          burst_len;
        int          enq_pct;
        logic        no_gaps;
        int unsigned g;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        have_next   = 1'b0;
        gap_left    = 0;
        error_count = 0;
        idle_cycles = 0;
        model_count = 0;

        // directed: empty dequeue, extremes, equal keys, fill, full enqueue, partial drain
        add_item(spq_pkg::FUNC_DEQ, 32'h0000_0000, 32'hffff_ffff, 0);
        add_item(spq_pkg::FUNC_ENQ, 32'h0000_0000, 32'h0000_0000, 0);
        add_item(spq_pkg::FUNC_ENQ, 32'h7fff_ffff, 32'hffff_ffff, 3);
        add_item(spq_pkg::FUNC_ENQ, 32'h8000_0000, 32'h0000_0005, 0);
        add_item(spq_pkg::FUNC_ENQ, 32'hffff_ffff, 32'h0000_0001, 14);
        add_item(spq_pkg::FUNC_ENQ, 32'h0000_0000, 32'h0000_0002, 0);
        // equal to the head
        add_item(spq_pkg::FUNC_ENQ, 32'h7fff_ffff, 32'h0000_0003, 1);
        for (n = 0; n < 10; n++)
            add_item(spq_pkg::FUNC_ENQ, $urandom_range(0, 3) - 2, $urandom,
                     (n % 2) ? 0 : n);
        add_item(spq_pkg::FUNC_ENQ, 32'h1234_5678, 32'hdead_beef, 0);
        for (n = 0; n < 7; n++)
            add_item(spq_pkg::FUNC_DEQ, $urandom, $urandom, (n < 4) ? 0 : 2);

        // random bursts that swing the fill level between empty and full
        n = 0;
        while (n < 1000) begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                g = no_gaps ? 0 : $urandom_range(0, 14);
                add_item(($urandom_range(0, 99) < enq_pct) ? spq_pkg::FUNC_ENQ
                                                           : spq_pkg::FUNC_DEQ,
                         draw_key(), $urandom, g);
                n++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_items.size() > 0 || have_next || i_start || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
